### hdl/kwq_pkg.sv
// kwq_pkg: types and constants shared by the keyed wait queue modules
// no dependencies
package kwq_pkg;

    localparam int HANDLE_W = 8;   // handle field width on the ports
    localparam int DISK_W   = 4;   // disk number field width
    localparam int OCC_W    = 5;   // occupancy field width

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_TAKE   = 1'b1;

    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_TAKEN    = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_RESP
    } seq_state_t;

    typedef struct packed {
        logic                func;
        logic [HANDLE_W-1:0] handle;
        logic [DISK_W-1:0]   disk;
    } kwq_req_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [OCC_W-1:0]    occupancy;
    } kwq_result_t;

    typedef struct packed {
        logic idle;   // sequencer can take a request
        logic done;   // result beat handed to the output register
    } kwq_seq_stat_t;

endpackage

### hdl/kwq_ram.sv
// kwq_ram: entry store, one write port and one registered read port
// no dependencies
module kwq_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 12
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [DATA_W-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [DATA_W-1:0]         rdata
);

    logic [DATA_W-1:0] entry_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            entry_mem[waddr] <= wdata;
        end
        rdata_reg <= entry_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/kwq_seq.sv
// kwq_seq: request sequencer, entry count and the shared key compare
// depends on kwq_pkg and kwq_ram
module kwq_seq
    import kwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int STORE_HW    = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  kwq_req_t      req,
    input  logic          out_free,
    output kwq_seq_stat_t stat,
    output kwq_result_t   result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = STORE_HW + DISK_W;

    seq_state_t            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                  issuing_reg, issuing_next;
    logic [AW-1:0]         chk_ptr_reg, chk_ptr_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic                  found_reg, found_next;
    logic [DISK_W-1:0]     key_reg, key_next;
    logic [HANDLE_W-1:0]   taken_reg, taken_next;
    status_t               status_reg, status_next;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic [EW-1:0]         rdata;
    logic [STORE_HW-1:0]   rd_handle;
    logic [DISK_W-1:0]     rd_disk;
    logic [CW-1:0]         cnt_m1;
    logic                  hit;
    logic                  last;

    kwq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (EW)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    assign rd_handle = rdata[EW-1:DISK_W];
    assign rd_disk   = rdata[DISK_W-1:0];
    assign cnt_m1    = count_reg - CW'(1);
    assign hit       = (rd_disk == key_reg);
    assign last      = (CW'(chk_ptr_reg) == cnt_m1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_IDLE;
            count_reg   <= '0;
            issuing_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issuing_reg <= issuing_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
        end
        rd_ptr_reg  <= rd_ptr_next;
        chk_ptr_reg <= chk_ptr_next;
        key_reg     <= key_next;
        taken_reg   <= taken_next;
        status_reg  <= status_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        issuing_next = issuing_reg;
        chk_ptr_next = chk_ptr_reg;
        chk_vld_next = 1'b0;
        found_next   = found_reg;
        key_next     = key_reg;
        taken_next   = taken_reg;
        status_next  = status_reg;
        we           = 1'b0;
        waddr        = count_reg[AW-1:0];
        wdata        = {req.handle[STORE_HW-1:0], req.disk};
        stat.idle    = 1'b0;
        stat.done    = 1'b0;

        case (state_reg)
            SQ_IDLE: begin
                stat.idle = 1'b1;
                if (start) begin
                    taken_next = '0;
                    if (req.func == FUNC_TAKE) begin
                        key_next     = req.disk;
                        found_next   = 1'b0;
                        rd_ptr_next  = '0;
                        issuing_next = (count_reg != '0);
                        status_next  = ST_NONE;
                        state_next   = (count_reg == '0) ? SQ_RESP : SQ_SCAN;
                    end else begin
                        if (count_reg < CW'(QUEUE_DEPTH)) begin
                            we          = 1'b1;
                            count_next  = count_reg + CW'(1);
                            status_next = ST_APPENDED;
                        end else begin
                            status_next = ST_DROPPED;
                        end
                        state_next = SQ_RESP;
                    end
                end
            end

            SQ_SCAN: begin
                // one read issued per cycle, its data checked in the cycle after
                if (issuing_reg) begin
                    chk_vld_next = 1'b1;
                    chk_ptr_next = rd_ptr_reg;
                    if (CW'(rd_ptr_reg) == cnt_m1) begin
                        issuing_next = 1'b0;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
                if (chk_vld_reg) begin
                    if (!found_reg) begin
                        if (hit) begin
                            found_next = 1'b1;
                            taken_next = HANDLE_W'(rd_handle);
                        end
                    end else begin
                        // close the gap: move the entry one place toward the head
                        we    = 1'b1;
                        waddr = chk_ptr_reg - AW'(1);
                        wdata = rdata;
                    end
                    if (last) begin
                        state_next = SQ_RESP;
                        if (found_reg || hit) begin
                            count_next  = cnt_m1;
                            status_next = ST_TAKEN;
                        end
                    end
                end
            end

            SQ_RESP: begin
                if (out_free) begin
                    stat.done  = 1'b1;
                    state_next = SQ_IDLE;
                end
            end

            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    assign result.status    = status_reg;
    assign result.handle    = taken_reg;
    assign result.occupancy = OCC_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == SQ_IDLE)
        else $error("request started while sequencer busy");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SQ_SCAN |-> count_reg != '0)
        else $error("scan running on an empty queue");

    a_shift_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && state_reg == SQ_SCAN) |-> found_reg)
        else $error("entry shifted before a match was found");

    a_take_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_SCAN && state_next == SQ_RESP && status_next == ST_TAKEN)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("take did not shrink the queue by one");

endmodule

### hdl/keyed_wait_queue.sv
// keyed_wait_queue: top level, input handshake and output result register
// depends on kwq_pkg and kwq_seq
//
// channel  direction  beat fields
// s_       in         s_func, s_process_handle, s_disk_number
// m_       out        m_status, m_taken_handle, m_occupancy
//
// append, or take on an empty queue: the result is registered once the output register is free
// take with N > 0 entries queued: every entry is scanned before the result is registered;
//   one entry read per cycle from the entry ram, checked by one key compare,
//   removal shifts in the same pass
// s_ready is high only while the sequencer is idle; a waiting result holds the next one
// reset clears the entry count and control; entry contents need no clearing
module keyed_wait_queue
    import kwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [HANDLE_W-1:0] s_process_handle,
    input  logic [DISK_W-1:0]   s_disk_number,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [HANDLE_W-1:0] m_taken_handle,
    output logic [OCC_W-1:0]    m_occupancy
);

    // stored handle bits: the port carries at most HANDLE_W of them
    localparam int STORE_HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    kwq_req_t      req;
    kwq_result_t   result;
    kwq_seq_stat_t stat;
    logic          start;
    logic          out_free;

    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [OCC_W-1:0]    m_occ_reg;

    assign req.func   = s_func;
    assign req.handle = s_process_handle;
    assign req.disk   = s_disk_number;

    assign s_ready  = stat.idle;
    assign start    = s_valid && stat.idle;
    assign out_free = !m_valid_reg || m_ready;

    kwq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STORE_HW    (STORE_HW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (req),
        .out_free (out_free),
        .stat     (stat),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (stat.done) begin
            m_status_reg <= result.status;
            m_handle_reg <= result.handle;
            m_occ_reg    <= result.occupancy;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_taken_handle = m_handle_reg;
    assign m_occupancy    = m_occ_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> (!m_valid_reg || m_ready))
        else $error("result beat overwritten before it was taken");

    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("ready high right after a request was taken");

    a_handle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.done && result.status != ST_TAKEN) |-> result.handle == '0)
        else $error("nonzero handle on a result other than taken");

endmodule

### bench/keyed_wait_queue_tb.sv
// keyed_wait_queue_tb: self-checking bench for the keyed wait queue, append and keyed take
// depends on kwq_pkg and the keyed_wait_queue top level; a scoreboard class predicts each beat
module keyed_wait_queue_tb;
    import kwq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int HANDLE_BITS    = 8;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((64'd1 << HANDLE_BITS) - 1);

    class wait_queue_scoreboard;
        logic [HANDLE_W-1:0] held_handle [QUEUE_DEPTH];
        logic [DISK_W-1:0]   held_disk   [QUEUE_DEPTH];
        int                  held_count;
        kwq_result_t         awaited [$];
        int unsigned         mismatches;
        int unsigned         requests;
        int unsigned         status_seen [4];

        function new();
            held_count = 0;
            mismatches = 0;
            requests   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // apply one accepted request to the shadow queue and queue up its result
        function void note_request(logic func, logic [HANDLE_W-1:0] handle,
                                   logic [DISK_W-1:0] disk);
            kwq_result_t r;
            int          slot;
            r.status    = ST_NONE;
            r.handle    = '0;
            r.occupancy = '0;
            requests++;
            if (func == FUNC_APPEND) begin
                if (held_count < QUEUE_DEPTH) begin
                    held_handle[held_count] = handle & HANDLE_MASK;
                    held_disk[held_count]   = disk;
                    held_count++;
                    r.status = ST_APPENDED;
                end else begin
                    r.status = ST_DROPPED;
                end
            end else begin
                slot = -1;
                for (int i = 0; i < held_count; i++)
                    if (slot < 0 && held_disk[i] == disk) slot = i;
                if (slot >= 0) begin
                    r.handle = held_handle[slot];
                    // close the gap, rest of the queue keeps its order
                    for (int k = slot; k + 1 < held_count; k++) begin
                        held_handle[k] = held_handle[k + 1];
                        held_disk[k]   = held_disk[k + 1];
                    end
                    held_count--;
                    r.status = ST_TAKEN;
                end
            end
            r.occupancy = OCC_W'(held_count);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [HANDLE_W-1:0] handle,
                                   logic [OCC_W-1:0] occupancy);
            kwq_result_t exp;
            if (awaited.size() == 0) begin
                $error("result beat with nothing outstanding: status %0d handle %0d occ %0d",
                       status, handle, occupancy);
                mismatches++;
                return;
            end
            exp = awaited.pop_front();
            status_seen[int'(exp.status)]++;
            if (status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, status);
                mismatches++;
            end
            if (handle !== exp.handle) begin
                $error("taken_handle: expected %0d, got %0d", exp.handle, handle);
                mismatches++;
            end
            if (occupancy !== exp.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp.occupancy, occupancy);
                mismatches++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_func;
    logic [HANDLE_W-1:0] s_process_handle;
    logic [DISK_W-1:0]   s_disk_number;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_status;
    logic [HANDLE_W-1:0] m_taken_handle;
    logic [OCC_W-1:0]    m_occupancy;

    wait_queue_scoreboard sb;
    bit                   hold_request;
    bit                   steady_phase;

    // disks for the directed fill: repeats of 3, no 7 so a miss can be forced
    logic [DISK_W-1:0] fill_disks [QUEUE_DEPTH] =
        '{4'd0, 4'd15, 4'd3, 4'd5, 4'd3, 4'd9, 4'd1, 4'd12,
          4'd3, 4'd6, 4'd2, 4'd14, 4'd8, 4'd10, 4'd4, 4'd11};

    keyed_wait_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_process_handle (s_process_handle),
        .s_disk_number    (s_disk_number),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_taken_handle   (m_taken_handle),
        .m_occupancy      (m_occupancy)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", sb.awaited.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer_request(input logic func, input logic [HANDLE_W-1:0] handle,
                                 input logic [DISK_W-1:0] disk);
        int gap;
        s_valid          <= 1'b1;
        s_func           <= func;
        s_process_handle <= handle;
        s_disk_number    <= disk;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(func, handle, disk);
        gap = steady_phase ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        while (sb.awaited.size() != 0) @(posedge aclk);
    endtask

    // result side: random ready pattern, plus one long hold-off on request
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
                stall = steady_phase ? 0 : pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_taken_handle, m_occupancy);
    end

    initial begin
        int                  append_pct;
        bit                  narrow;
        bit                  is_append;
        logic [HANDLE_W-1:0] handle;
        logic [DISK_W-1:0]   disk;
        int                  pct_table [5];

        pct_table        = '{25, 50, 75, 90, 10};
        sb               = new();
        hold_request     = 1'b0;
        steady_phase     = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_func           = FUNC_APPEND;
        s_process_handle = '0;
        s_disk_number    = '0;
        m_ready          = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: miss on empty, fill to full, drop, keyed takes from the middle and the head, a keyed miss
        offer_request(FUNC_TAKE, 8'h00, 4'd7);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            handle = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : HANDLE_W'(i * 17) ^ 8'h3C;
            offer_request(FUNC_APPEND, handle, fill_disks[i]);
        end
        offer_request(FUNC_APPEND, 8'h77, 4'd7);
        offer_request(FUNC_TAKE, 8'hFF, 4'd3);
        offer_request(FUNC_TAKE, 8'h00, 4'd7);
        offer_request(FUNC_TAKE, 8'h00, 4'd15);
        offer_request(FUNC_TAKE, 8'hFF, 4'd0);
        offer_request(FUNC_APPEND, 8'hC3, 4'd3);
        offer_request(FUNC_TAKE, 8'h00, 4'd3);

        // sender waits for every result before the random part
        s_valid <= 1'b0;
        wait_for_drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            append_pct   = pct_table[phase % 5];
            narrow       = (phase % 2) == 1;
            steady_phase = (phase == 4 || phase == 7);
            if (phase == 2) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                is_append = $urandom_range(0, 99) < append_pct;
                handle    = HANDLE_W'($urandom_range(0, 255));
                if (is_append)
                    disk = DISK_W'(narrow ? $urandom_range(0, 3) : $urandom_range(0, 15));
                else if (sb.held_count > 0 && $urandom_range(0, 3) != 0)
                    disk = sb.held_disk[$urandom_range(0, sb.held_count - 1)];
                else
                    disk = DISK_W'($urandom_range(0, 15));
                offer_request(is_append ? FUNC_APPEND : FUNC_TAKE, handle, disk);
            end
            if (phase == 5) begin
                s_valid <= 1'b0;
                wait_for_drain();
            end
        end
        s_valid <= 1'b0;
        steady_phase = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.awaited.size() != 0)
            $error("%0d expected results never arrived", sb.awaited.size());
        $display("%0d requests: %0d appended, %0d dropped when full, %0d taken, %0d misses",
                 sb.requests, sb.status_seen[ST_APPENDED], sb.status_seen[ST_DROPPED],
                 sb.status_seen[ST_TAKEN], sb.status_seen[ST_NONE]);
        $display("%0d field mismatches or stray beats", sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/kwq_pkg.sv
hdl/kwq_ram.sv
hdl/kwq_seq.sv
hdl/keyed_wait_queue.sv
bench/keyed_wait_queue_tb.sv
